// ----- src/dbsp_pkg.sv -----
// Shared types and constants of the detector buffer stream parser.
package dbsp_pkg;

    localparam logic [63:0] SEPARATOR_WORD   = 64'h0000_FFFF_5555_AAAA;
    localparam logic [15:0] CLOSING_LENGTH   = 16'hFFFF;
    localparam int unsigned LENGTH_BIAS      = 21;
    localparam int unsigned WORDS_PER_EVENT  = 3;
    localparam int unsigned FIRST_EVENT_BYTE = 43;
    localparam int unsigned LAST_EVENT_PHASE = 5;
    localparam int unsigned LEN_HI_BYTE      = 0;
    localparam int unsigned LEN_LO_BYTE      = 1;
    localparam int unsigned STAMP_FIRST_BYTE = 12;
    localparam int unsigned STAMP_LAST_BYTE  = 17;
    localparam int unsigned SEPARATOR_BYTES  = 8;

    typedef struct packed {
        logic        is_data_buffer;
        logic [47:0] buffer_timestamp;
        logic [15:0] length_words;
        logic [9:0]  events_seen;
        logic        has_super;
        logic [23:0] run_number;
        logic        overflowed;
    } summary_t;

endpackage

// ----- src/dbsp_core.sv -----
// Per-byte buffer state, field capture and separator detection.
module dbsp_core #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    input  logic              go,
    input  logic [7:0]        byte_in,
    output logic              summary_fire,
    output dbsp_pkg::summary_t summary
);
    import dbsp_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES);
    localparam logic [15:0] NEED_INIT = 16'(LENGTH_BIAS + WORDS_PER_EVENT);

    logic [3:0]       channel_reg;
    logic [63:0]      window_reg, window_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [47:0]      stamp_reg, stamp_next;
    logic [9:0]       evcnt_reg, evcnt_next;
    logic             super_reg, super_next;
    logic [23:0]      run_reg, run_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      need_reg, need_next;
    logic [2:0]       stamp_off;
    logic [2:0]       stamp_lane;
    logic             is_data;
    logic             match;

    always_comb
    begin
        window_next = {window_reg[55:0], byte_in};
        pos_next    = pos_reg;
        len_next    = len_reg;
        stamp_next  = stamp_reg;
        evcnt_next  = evcnt_reg;
        super_next  = super_reg;
        ovf_next    = ovf_reg;
        phase_next  = phase_reg;
        need_next   = need_reg;
        stamp_off   = 3'(pos_reg - POS_W'(STAMP_FIRST_BYTE));
        stamp_lane  = {stamp_off[2:1], ~stamp_off[0]};

        if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(LEN_HI_BYTE))
            begin
                len_next[15:8] = byte_in;
            end
            else if (pos_reg == POS_W'(LEN_LO_BYTE))
            begin
                len_next[7:0] = byte_in;
            end
            else if (pos_reg >= POS_W'(STAMP_FIRST_BYTE) &&
                     pos_reg <= POS_W'(STAMP_LAST_BYTE))
            begin
                stamp_next[stamp_lane*8 +: 8] = byte_in;
            end
            else if (pos_reg >= POS_W'(FIRST_EVENT_BYTE))
            begin
                if (phase_reg == 3'(LAST_EVENT_PHASE))
                begin
                    // The event counts when 3*(index+1)+21 fits in the length.
                    phase_next = '0;
                    need_next  = need_reg + 16'(WORDS_PER_EVENT);
                    if (need_reg <= len_reg)
                    begin
                        evcnt_next = evcnt_reg + 10'd1;
                        if (byte_in[3:0] == channel_reg)
                        begin
                            super_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                end
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end

        match   = (pos_reg >= POS_W'(SEPARATOR_BYTES - 1)) &&
                  (window_next == SEPARATOR_WORD);
        is_data = (len_next != CLOSING_LENGTH);
        run_next = run_reg;
        if (match && is_data && super_next)
        begin
            run_next = run_reg + 24'd1;
        end

        summary.is_data_buffer   = is_data;
        summary.buffer_timestamp = is_data ? stamp_next : '0;
        summary.length_words     = len_next;
        summary.events_seen      = is_data ? evcnt_next : '0;
        summary.has_super        = is_data && super_next;
        summary.run_number       = run_next;
        summary.overflowed       = ovf_next;
        summary_fire             = go && match;

        if (match)
        begin
            pos_next   = '0;
            len_next   = '0;
            stamp_next = '0;
            evcnt_next = '0;
            super_next = 1'b0;
            ovf_next   = 1'b0;
            phase_next = '0;
            need_next  = NEED_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= '0;
            window_reg  <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
            stamp_reg   <= '0;
            evcnt_reg   <= '0;
            super_reg   <= 1'b0;
            run_reg     <= '0;
            ovf_reg     <= 1'b0;
            phase_reg   <= '0;
            need_reg    <= NEED_INIT;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                channel_reg <= cfg_wr_data;
            end
            if (go)
            begin
                window_reg <= window_next;
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                stamp_reg  <= stamp_next;
                evcnt_reg  <= evcnt_next;
                super_reg  <= super_next;
                run_reg    <= run_next;
                ovf_reg    <= ovf_next;
                phase_reg  <= phase_next;
                need_reg   <= need_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= POS_LIMIT)
        else $error("Byte position ran past the buffer capacity.");
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= 3'(LAST_EVENT_PHASE))
        else $error("Event phase left its range.");
    assert property (@(posedge clk) disable iff (!rst_n)
        summary_fire |=> (pos_reg == '0) && !ovf_reg && !super_reg && (evcnt_reg == '0))
        else $error("Buffer state was not cleared after a summary.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && !summary_fire && pos_reg < POS_LIMIT) |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("Byte position did not advance on a stored byte.");

endmodule

// ----- src/detector_buffer_stream_parser.sv -----
// Top level of the detector buffer stream parser: input and result registers around the core.
// One byte is accepted per clock cycle while in_stall is low; a byte passes the input register,
// then the parse logic, and its summary, if any, is loaded into the result register. The rate
// is set by the state update in the parse core, which reads and writes all buffer state once
// per byte. A summary transaction is produced on the byte that completes the separator
// 00 00 FF FF 55 55 AA AA; the input stalls only while a summary is held.
module detector_buffer_stream_parser #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_data_buffer,
    output logic [47:0] buffer_timestamp,
    output logic [15:0] length_words,
    output logic [9:0]  events_seen,
    output logic        has_super,
    output logic [23:0] run_number,
    output logic        overflowed
);
    import dbsp_pkg::*;

    logic     s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic     s1_adv;
    logic     in_accept;
    logic     out_valid_reg;
    summary_t out_reg;
    summary_t summary;
    logic     summary_fire;

    assign s1_adv    = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    dbsp_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (s1_valid_reg && s1_adv),
        .byte_in     (s1_byte_reg),
        .summary_fire(summary_fire),
        .summary     (summary)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (summary_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
        end
        if (summary_fire)
        begin
            out_reg <= summary;
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_data_buffer   = out_reg.is_data_buffer;
    assign buffer_timestamp = out_reg.buffer_timestamp;
    assign length_words     = out_reg.length_words;
    assign events_seen      = out_reg.events_seen;
    assign has_super        = out_reg.has_super;
    assign run_number       = out_reg.run_number;
    assign overflowed       = out_reg.overflowed;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("Input stalled while the result register was free.");
    assert property (@(posedge clk) disable iff (!rst_n)
        summary_fire |-> !(out_valid_reg && out_stall))
        else $error("A summary would overwrite a held transaction.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_data_buffer) |->
        (events_seen == '0) && !has_super && (buffer_timestamp == '0))
        else $error("A closing signature carried buffer fields.");

endmodule

// ----- tb/dbsp_scoreboard_pkg.sv -----
// Scoreboard class that predicts the buffer summaries of the stream parser and checks them.
package dbsp_scoreboard_pkg;

    import dbsp_pkg::*;

    class summary_scoreboard;

        localparam int unsigned EVENT_BYTES = LAST_EVENT_PHASE + 1;

        int unsigned capacity;
        logic [63:0] window;
        int unsigned fill;
        logic [15:0] length_word;
        logic [47:0] stamp;
        logic [9:0]  event_count;
        bit          super_hit;
        logic [23:0] run_count;
        bit          overflow;
        logic [3:0]  channel;
        summary_t    due_summaries[$];
        int          errors;

        function new(int unsigned buffer_bytes);
            capacity    = buffer_bytes;
            window      = '0;
            run_count   = '0;
            channel     = '0;
            errors      = 0;
            start_buffer();
        endfunction

        function void start_buffer();
            fill        = 0;
            length_word = '0;
            stamp       = '0;
            event_count = '0;
            super_hit   = 1'b0;
            overflow    = 1'b0;
        endfunction

        function void set_channel(logic [3:0] id);
            channel = id;
        endfunction

        function int outstanding();
            return due_summaries.size();
        endfunction

        function void store_byte(int unsigned pos, logic [7:0] b);
            int unsigned shift;
            int unsigned allowed;
            if (pos == LEN_HI_BYTE)
            begin
                length_word[15:8] = b;
            end
            else if (pos == LEN_LO_BYTE)
            begin
                length_word[7:0] = b;
            end
            else if (pos >= STAMP_FIRST_BYTE && pos <= STAMP_LAST_BYTE)
            begin
                shift = ((pos - STAMP_FIRST_BYTE) >> 1) * 16 + (pos[0] ? 0 : 8);
                stamp[shift +: 8] = b;
            end
            else if (pos >= FIRST_EVENT_BYTE &&
                     (pos - FIRST_EVENT_BYTE) % EVENT_BYTES == LAST_EVENT_PHASE)
            begin
                allowed = (length_word >= LENGTH_BIAS) ?
                          (length_word - LENGTH_BIAS) / WORDS_PER_EVENT : 0;
                if ((pos - FIRST_EVENT_BYTE) / EVENT_BYTES < allowed)
                begin
                    event_count = event_count + 10'd1;
                    if (b[3:0] == channel)
                    begin
                        super_hit = 1'b1;
                    end
                end
            end
        endfunction

        function void absorb_byte(logic [7:0] b);
            summary_t s;
            bit       is_data;
            window = {window[55:0], b};
            if (fill < capacity)
            begin
                store_byte(fill, b);
                fill++;
            end
            else
            begin
                overflow = 1'b1;
            end
            if (fill < SEPARATOR_BYTES || window != SEPARATOR_WORD)
            begin
                return;
            end
            is_data = (length_word != CLOSING_LENGTH);
            if (is_data && super_hit)
            begin
                run_count = run_count + 24'd1;
            end
            s.is_data_buffer   = is_data;
            s.buffer_timestamp = is_data ? stamp : '0;
            s.length_words     = length_word;
            s.events_seen      = is_data ? event_count : '0;
            s.has_super        = is_data && super_hit;
            s.run_number       = run_count;
            s.overflowed       = overflow;
            due_summaries.push_back(s);
            start_buffer();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("summary field %s: expected %0h, actual %0h", name, want, got);
                end
            end
        endfunction

        function void check_summary(summary_t got);
            summary_t want;
            if (due_summaries.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("summary transaction with none expected: %h", got);
                end
                return;
            end
            want = due_summaries.pop_front();
            compare_field("is_data_buffer", 64'(want.is_data_buffer),
                          64'(got.is_data_buffer));
            compare_field("buffer_timestamp", 64'(want.buffer_timestamp),
                          64'(got.buffer_timestamp));
            compare_field("length_words", 64'(want.length_words), 64'(got.length_words));
            compare_field("events_seen", 64'(want.events_seen), 64'(got.events_seen));
            compare_field("has_super", 64'(want.has_super), 64'(got.has_super));
            compare_field("run_number", 64'(want.run_number), 64'(got.run_number));
            compare_field("overflowed", 64'(want.overflowed), 64'(got.overflowed));
        endfunction

    endclass

endpackage

// ----- tb/detector_buffer_stream_parser_test.sv -----
// Self-checking testbench that streams detector buffers through the parser and checks each summary.
module detector_buffer_stream_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dbsp_pkg::*;
    import dbsp_scoreboard_pkg::*;

    localparam int BUFFER_BYTES = 2048;
    localparam int QUIET_LIMIT  = 2000;
    localparam int EVENT_BYTES  = LAST_EVENT_PHASE + 1;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte   = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        is_data_buffer;
    logic [47:0] buffer_timestamp;
    logic [15:0] length_words;
    logic [9:0]  events_seen;
    logic        has_super;
    logic [23:0] run_number;
    logic        overflowed;

    summary_scoreboard sb;
    bit          calm = 1'b0;
    logic [3:0]  super_id = '0;
    int          sent_bytes = 0;
    int          sink_hold = 0;
    int          quiet_cycles = 0;

    detector_buffer_stream_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_data_buffer(is_data_buffer),
        .buffer_timestamp(buffer_timestamp),
        .length_words(length_words),
        .events_seen(events_seen),
        .has_super(has_super),
        .run_number(run_number),
        .overflowed(overflowed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            sink_hold <= $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_summary({is_data_buffer, buffer_timestamp, length_words, events_seen,
                              has_super, run_number, overflowed});
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("detector_buffer_stream_parser: mismatch");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.absorb_byte(b);
        sent_bytes++;
    endtask

    task automatic push_separator(input int count);
        for (int k = 0; k < count; k++)
        begin
            push_byte(SEPARATOR_WORD[63 - 8 * k -: 8]);
        end
    endtask

    task automatic push_buffer(input logic [15:0] len, input int body);
        logic [7:0] b;
        for (int pos = 0; pos < body; pos++)
        begin
            b = 8'($urandom_range(0, 255));
            if (pos == LEN_HI_BYTE)
            begin
                b = len[15:8];
            end
            else if (pos == LEN_LO_BYTE)
            begin
                b = len[7:0];
            end
            else if (pos >= FIRST_EVENT_BYTE &&
                     (pos - FIRST_EVENT_BYTE) % EVENT_BYTES == LAST_EVENT_PHASE &&
                     $urandom_range(0, 2) == 0)
            begin
                b[3:0] = super_id;
            end
            push_byte(b);
        end
        push_separator(SEPARATOR_BYTES);
    endtask

    task automatic write_channel(input logic [3:0] id);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        super_id = id;
        sb.set_channel(id);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int target);
        logic [15:0] len;
        int          body;
        while (sent_bytes < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 9))
                    0: len = CLOSING_LENGTH;
                    1: len = 16'($urandom_range(0, LENGTH_BIAS - 1));
                    2: len = 16'($urandom_range(16'hFF00, 16'hFFFE));
                    3: len = 16'($urandom_range(0, 16'hFFFF));
                    default: len = 16'(LENGTH_BIAS + WORDS_PER_EVENT * $urandom_range(0, 12)
                                       + $urandom_range(0, 2));
                endcase
                body = ($urandom_range(0, 7) == 0) ? $urandom_range(121, 300)
                                                   : $urandom_range(0, 120);
                push_buffer(len, body);
            end
            else
            begin
                repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                begin
                    push_separator($urandom_range(1, SEPARATOR_BYTES - 1));
                end
            end
        end
    endtask

    initial
    begin
        sb = new(BUFFER_BYTES);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_channel(4'hF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h55);
        push_byte(8'h55);
        push_byte(8'hAA);
        push_byte(8'hAA);
        push_separator(SEPARATOR_BYTES);
        push_separator(SEPARATOR_BYTES);
        settle();

        write_channel(4'h0);
        run_phase(450);
        settle();
        write_channel(4'hA);
        run_phase(900);
        settle();
        write_channel(4'h5);
        run_phase(1300);
        settle();
        write_channel(4'($urandom_range(0, 15)));
        run_phase(1550);
        settle();
        calm = 1'b1;
        write_channel(4'hF);
        run_phase(sent_bytes + 350);
        settle();
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("detector_buffer_stream_parser: match");
        end
        else
        begin
            $display("detector_buffer_stream_parser: mismatch");
        end
        $finish;
    end

endmodule
